// ===== src/scm_pkg.sv =====
package scm_pkg;

    // Default fixed-point formats of the angle and of the results.
    localparam int ANGLE_FRAC_BITS_DEF  = 24;
    localparam int RESULT_FRAC_BITS_DEF = 30;

    // Reduction constants: 1/(2*pi) in Q.32, 2*pi and pi in Q.48.
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'h28BE60DC;
    localparam logic [50:0] TWO_PI_Q48     = 51'h6487ED5110B46;
    localparam logic [49:0] PI_Q48         = 50'h3243F6A8885A3;

    // The constant multiply by 2*pi is split into a low and a high partial product.
    localparam int          TWO_PI_LO_BITS = 26;
    localparam logic [25:0] TWO_PI_LO      = TWO_PI_Q48[25:0];
    localparam logic [24:0] TWO_PI_HI      = TWO_PI_Q48[50:26];

    // Half of one unit after a shift by 30.
    localparam logic [64:0] ROUND_HALF_Q30 = 65'd1 << 29;

    // Horner chain: leading coefficient plus five multiply-accumulate steps.
    localparam int HORNER_STEPS = 5;

    localparam logic signed [31:0] SIN_COEF [6] = '{
        -32'sd26, 32'sd2956, -32'sd213040, 32'sd8947846, -32'sd178956974, 32'sd1073741824
    };
    localparam logic signed [31:0] COS_COEF [6] = '{
        -32'sd280, 32'sd26586, -32'sd1491253, 32'sd44739212, -32'sd536870912,
        32'sd1073741824
    };

    // Values that travel alongside the polynomial evaluation.
    typedef struct packed {
        logic [30:0] ym;    // folded angle magnitude, Q.30
        logic [31:0] y2;    // its square, Q.30
        logic        yneg;  // folded angle was negative
        logic        flip;  // angle was folded, cosine changes sign
    } side_t;

    // Shift a Q.60 product back to Q.30, rounding half away from zero.
    function automatic logic signed [34:0] rnd_q30(input logic signed [64:0] x);
        logic [64:0] m;
        logic [64:0] r;
        m = x[64] ? 65'(-x) : 65'(x);
        r = (m + ROUND_HALF_Q30) >> 30;
        return x[64] ? -$signed(r[34:0]) : $signed(r[34:0]);
    endfunction

endpackage

// ===== src/sin_cos_minimax_top.sv =====
// Fixed-point sine and cosine. Each request carries one angle in radians
// (signed, ANGLE_FRAC_BITS fraction bits); each result carries the sine and
// the cosine as signed values with RESULT_FRAC_BITS fraction bits, saturated
// to +-1.0. The angle is reduced modulo 2*pi, folded into [-pi/2, pi/2] and
// fed to minimax polynomials evaluated by Horner's rule. The pipeline has 20
// register stages, and a new request is taken in every cycle while the
// result side does not stall. The stages hold the five Horner steps, each
// of which needs one multiplier stage and one rounding stage, plus the
// reduction and the final scaling. Stalls on the result side are absorbed
// by empty stages before requests are held back.
module sin_cos_minimax_top #(
    parameter int ANGLE_FRAC_BITS  = scm_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int RESULT_FRAC_BITS = scm_pkg::RESULT_FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] angle
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [31:0] sine, [63:32] cosine
);

    import scm_pkg::*;

    // Quotient width and shift into Q.48.
    localparam int QW       = 32 - ANGLE_FRAC_BITS;
    localparam int EXT_SH   = 48 - ANGLE_FRAC_BITS;
    localparam int Q_RND_SH = ANGLE_FRAC_BITS + 31;

    // Final scaling.
    localparam int                FIN_SHIFT = 30 - RESULT_FRAC_BITS;
    localparam logic [33:0]       FIN_HALF  = (FIN_SHIFT == 0) ? 34'd0 :
                                              (34'd1 << (FIN_SHIFT - 1));
    localparam logic signed [34:0] FIN_LIM  = $signed(35'd1 << RESULT_FRAC_BITS);

    // Stage positions.
    localparam int ST_PROD = 0;
    localparam int ST_Q    = 1;
    localparam int ST_PP   = 2;
    localparam int ST_Y    = 3;
    localparam int ST_YM   = 4;
    localparam int ST_SQ   = 5;
    localparam int ST_Y2   = 6;
    localparam int ST_SP   = ST_Y2 + 2 * HORNER_STEPS + 1;
    localparam int ST_SC   = ST_SP + 1;
    localparam int ST_OUT  = ST_SC + 1;
    localparam int NST     = ST_OUT + 1;

    // Round the final Q.30 value to the result format and saturate.
    function automatic logic [31:0] finish_q(input logic signed [33:0] x);
        logic [33:0]        m;
        logic [33:0]        r;
        logic signed [34:0] v;
        m = x[33] ? 34'(-x) : 34'(x);
        r = (m + FIN_HALF) >> FIN_SHIFT;
        v = x[33] ? -$signed({1'b0, r}) : $signed({1'b0, r});
        if (v > FIN_LIM) begin
            v = FIN_LIM;
        end
        if (v < -FIN_LIM) begin
            v = -FIN_LIM;
        end
        return v[31:0];
    endfunction

    logic [NST-1:0] valid_reg;
    logic [NST-1:0] adv;

    logic [61:0]        prod_reg,  prod_next;
    logic [31:0]        mag0_reg,  mag0_next;
    logic [ST_PP:0]     aneg_reg;
    logic               aneg_next;
    logic [QW-1:0]      q_reg,     q_next;
    logic [52:0]        ext1_reg,  ext1_next;
    logic [52:0]        ext2_reg;
    logic [QW+25:0]     plo_reg,   plo_next;
    logic [QW+24:0]     phi_reg,   phi_next;
    logic signed [52:0] y_reg,     y_next;
    logic [61:0]        sq_reg,    sq_next;
    side_t              side_reg  [ST_YM:ST_SP];
    side_t              side_next [ST_YM:ST_SP];

    logic signed [64:0] prod_s_reg [1:HORNER_STEPS];
    logic signed [64:0] prod_s_next [1:HORNER_STEPS];
    logic signed [64:0] prod_c_reg [1:HORNER_STEPS];
    logic signed [64:0] prod_c_next [1:HORNER_STEPS];
    logic signed [31:0] acc_s_reg  [1:HORNER_STEPS];
    logic signed [31:0] acc_s_next [1:HORNER_STEPS];
    logic signed [31:0] acc_c_reg  [1:HORNER_STEPS];
    logic signed [31:0] acc_c_next [1:HORNER_STEPS];
    logic signed [31:0] acc_s_in   [1:HORNER_STEPS];
    logic signed [31:0] acc_c_in   [1:HORNER_STEPS];

    logic signed [63:0] sp_reg,  sp_next;
    logic signed [31:0] cp_reg,  cp_next;
    logic signed [33:0] s_reg,   s_next;
    logic signed [33:0] c_reg,   c_next;
    logic [31:0]        sin_reg, sin_next;
    logic [31:0]        cos_reg, cos_next;

    // A stage takes new contents when it is empty or its successor moves on.
    always_comb begin
        adv[NST-1] = !valid_reg[NST-1] || m_tready;
        for (int k = NST - 2; k >= 0; k--) begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign s_tready = adv[0];
    assign m_tvalid = valid_reg[ST_OUT];
    assign m_tdata  = {cos_reg, sin_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (adv[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Sign flag of the angle travels through the reduction stages.
    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            aneg_reg[0] <= aneg_next;
        end
        for (int k = 1; k <= ST_PP; k++) begin
            if (adv[k]) begin
                aneg_reg[k] <= aneg_reg[k-1];
            end
        end
    end

    // Magnitude of the angle times 1/(2*pi).
    always_comb begin
        aneg_next = s_tdata[31];
        mag0_next = aneg_next ? 32'(-s_tdata) : s_tdata;
        prod_next = 62'(mag0_next) * 62'(INV_TWO_PI_Q32);
    end

    // Quotient rounded half up on the magnitude; angle moved to Q.48.
    always_comb begin
        logic [63:0] qs;
        qs        = 64'(prod_reg) + (64'd1 << Q_RND_SH);
        q_next    = qs[63 -: QW];
        ext1_next = {21'd0, mag0_reg} << EXT_SH;
    end

    // Partial products of quotient times 2*pi.
    always_comb begin
        plo_next = (QW + 26)'(q_reg) * (QW + 26)'(TWO_PI_LO);
        phi_next = (QW + 25)'(q_reg) * (QW + 25)'(TWO_PI_HI);
    end

    // Remainder with the sign of the angle; only its low bits matter.
    always_comb begin
        logic [52:0] qt;
        logic [52:0] diff;
        qt     = 53'(plo_reg) + (53'(phi_reg) << TWO_PI_LO_BITS);
        diff   = ext2_reg - qt;
        y_next = aneg_reg[ST_PP] ? $signed(-diff) : $signed(diff);
    end

    // Fold into [-pi/2, pi/2], take the magnitude and round to Q.30, then
    // pass the side values along and add the square once it is known.
    always_comb begin
        logic signed [53:0] two_y;
        logic signed [53:0] pi54;
        logic signed [52:0] yf;
        logic [52:0]        yabs;
        logic [52:0]        yrnd;
        logic               gt;
        logic               lt;
        logic [61:0]        y2s;
        two_y = $signed({y_reg, 1'b0});
        pi54  = $signed(54'(PI_Q48));
        gt    = two_y > pi54;
        lt    = two_y < -pi54;
        if (gt) begin
            yf = $signed(53'(PI_Q48)) - y_reg;
        end else if (lt) begin
            yf = -$signed(53'(PI_Q48)) - y_reg;
        end else begin
            yf = y_reg;
        end
        yabs = yf[52] ? 53'(-yf) : 53'(yf);
        yrnd = yabs + (53'd1 << 17);
        side_next[ST_YM].ym   = yrnd[48:18];
        side_next[ST_YM].y2   = '0;
        side_next[ST_YM].yneg = yf[52];
        side_next[ST_YM].flip = gt || lt;
        for (int k = ST_YM + 1; k <= ST_SP; k++) begin
            side_next[k] = side_reg[k-1];
        end
        y2s = sq_reg + (62'd1 << 29);
        side_next[ST_Y2].y2 = y2s[61:30];
    end

    // Square of the folded angle.
    assign sq_next = 62'(side_reg[ST_YM].ym) * 62'(side_reg[ST_YM].ym);

    // Horner steps: one multiply stage and one round-and-add stage each.
    always_comb begin
        logic signed [32:0] y2v;
        acc_s_in[1] = SIN_COEF[0];
        acc_c_in[1] = COS_COEF[0];
        for (int j = 2; j <= HORNER_STEPS; j++) begin
            acc_s_in[j] = acc_s_reg[j-1];
            acc_c_in[j] = acc_c_reg[j-1];
        end
        for (int j = 1; j <= HORNER_STEPS; j++) begin
            y2v            = $signed({1'b0, side_reg[ST_Y2 + 2 * j - 2].y2});
            prod_s_next[j] = acc_s_in[j] * y2v;
            prod_c_next[j] = acc_c_in[j] * y2v;
            acc_s_next[j]  = 32'(rnd_q30(prod_s_reg[j]) + 35'(SIN_COEF[j]));
            acc_c_next[j]  = 32'(rnd_q30(prod_c_reg[j]) + 35'(COS_COEF[j]));
        end
    end

    // Sine: odd polynomial times the folded magnitude, then signs applied.
    // The cosine waits one stage beside the sine product.
    always_comb begin
        logic signed [34:0] s_rnd;
        sp_next = acc_s_reg[HORNER_STEPS] * $signed({1'b0, side_reg[ST_SP-1].ym});
        cp_next = acc_c_reg[HORNER_STEPS];
        s_rnd   = rnd_q30({sp_reg[63], sp_reg});
        s_next  = side_reg[ST_SP].yneg ? 34'(-s_rnd) : 34'(s_rnd);
        c_next  = side_reg[ST_SP].flip ? -(34'(cp_reg)) : 34'(cp_reg);
        sin_next = finish_q(s_reg);
        cos_next = finish_q(c_reg);
    end

    // Pipeline data registers.
    always_ff @(posedge aclk) begin
        if (adv[ST_PROD]) begin
            prod_reg <= prod_next;
            mag0_reg <= mag0_next;
        end
        if (adv[ST_Q]) begin
            q_reg    <= q_next;
            ext1_reg <= ext1_next;
        end
        if (adv[ST_PP]) begin
            plo_reg  <= plo_next;
            phi_reg  <= phi_next;
            ext2_reg <= ext1_reg;
        end
        if (adv[ST_Y]) begin
            y_reg <= y_next;
        end
        if (adv[ST_SQ]) begin
            sq_reg <= sq_next;
        end
        for (int k = ST_YM; k <= ST_SP; k++) begin
            if (adv[k]) begin
                side_reg[k] <= side_next[k];
            end
        end
        for (int j = 1; j <= HORNER_STEPS; j++) begin
            if (adv[ST_Y2 + 2 * j - 1]) begin
                prod_s_reg[j] <= prod_s_next[j];
                prod_c_reg[j] <= prod_c_next[j];
            end
            if (adv[ST_Y2 + 2 * j]) begin
                acc_s_reg[j] <= acc_s_next[j];
                acc_c_reg[j] <= acc_c_next[j];
            end
        end
        if (adv[ST_SP]) begin
            sp_reg <= sp_next;
            cp_reg <= cp_next;
        end
        if (adv[ST_SC]) begin
            s_reg <= s_next;
            c_reg <= c_next;
        end
        if (adv[ST_OUT]) begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

endmodule
